/* hw/rtl/clock_offset_estimator_core_assert.svh */
// Assertion macros shared by the clock offset estimator modules.
`ifndef CLOCK_OFFSET_ESTIMATOR_CORE_ASSERT_SVH
`define CLOCK_OFFSET_ESTIMATOR_CORE_ASSERT_SVH
// Assert that a condition implies a property on the same edge.
`define COE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Assert that a condition implies a property on the following edge.
`define COE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* hw/rtl/coe_pkg.sv */
// ----------------------------------------------------------------------------
// coe_pkg
// Shared types and constants of the clock offset estimator.
// ----------------------------------------------------------------------------
package coe_pkg;

  localparam int unsigned QOne = 65536;

  // Register byte addresses (index times four).
  localparam logic [3:0] RegReject = 4'd0;
  localparam logic [3:0] RegGate   = 4'd4;
  localparam logic [3:0] RegAlpha  = 4'd8;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture input, compute rtt and raw offset
    logic sort_step; // one compare-exchange pass step
    logic sort_init; // copy window into sort buffer
    logic decide;    // evaluate gate
    logic mul_lo;    // first partial products
    logic mul_hi;    // second partial products
    logic commit;    // write window and averages
  } coe_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic gate_on;
  } coe_sts_t;

endpackage

/* hw/rtl/coe_ctrl.sv */
// ----------------------------------------------------------------------------
// coe_ctrl
// Sequencer: load, sort the window when the gate is on, gate, blend, commit, present the result.
// ----------------------------------------------------------------------------
module coe_ctrl
  import coe_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  coe_sts_t sts_i,
  output coe_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_SINIT, S_SORT, S_DECIDE, S_MLO, S_MHI, S_COMMIT
  } state_e;

  localparam int unsigned CntW = $clog2(WINDOW_DEPTH + 1);

  state_e          state_q;
  logic [CntW-1:0] cnt_q;
  logic            out_valid_q;
  logic            commit_go;

  // Commit once the output register is free or its transfer happens now.
  assign commit_go   = (state_q == S_COMMIT) && (!out_valid_q || out_ready_i);
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o = '0;
    cmd_o.load      = in_valid_i && in_ready_o;
    cmd_o.sort_init = (state_q == S_SINIT);
    cmd_o.sort_step = (state_q == S_SORT);
    cmd_o.decide    = (state_q == S_DECIDE);
    cmd_o.mul_lo    = (state_q == S_MLO);
    cmd_o.mul_hi    = (state_q == S_MHI);
    cmd_o.commit    = commit_go;
  end

  // Advance the sequence; hold the result until its transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (commit_go) out_valid_q <= 1'b1;
      else if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) state_q <= S_LOAD;
        end
        S_LOAD: begin
          state_q <= sts_i.gate_on ? S_SINIT : S_DECIDE;
        end
        S_SINIT: begin
          cnt_q   <= '0;
          state_q <= S_SORT;
        end
        S_SORT: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntW'(WINDOW_DEPTH - 1)) state_q <= S_DECIDE;
        end
        S_DECIDE: state_q <= S_MLO;
        S_MLO:    state_q <= S_MHI;
        S_MHI:    state_q <= S_COMMIT;
        S_COMMIT: begin
          if (commit_go) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`include "clock_offset_estimator_core_assert.svh"
  `COE_ASSERT_IMP(a_ready_idle, clk_i, rst_ni, in_ready_o, state_q == S_IDLE)
  `COE_ASSERT_NEXT(a_commit_valid, clk_i, rst_ni, commit_go, out_valid_q)
  `COE_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_q && !out_ready_i, out_valid_q)

endmodule

/* hw/rtl/coe_datapath.sv */
// ----------------------------------------------------------------------------
// coe_datapath
// Window storage, odd-even sort over cycles, median gate and EWMA blend.
// ----------------------------------------------------------------------------
module coe_datapath
  import coe_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = 16,
  parameter int unsigned TIME_BITS    = 48
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  coe_cmd_t              cmd_i,
  output coe_sts_t              sts_o,
  input  logic [TIME_BITS-1:0]  send_i,
  input  logic [TIME_BITS-1:0]  server_i,
  input  logic [TIME_BITS-1:0]  recv_i,
  input  logic [31:0]           reject_i,
  input  logic [4:0]            gate_i,
  input  logic [16:0]           alpha_i,
  output logic                  accepted_o,
  output logic                  est_valid_o,
  output logic signed [TIME_BITS:0]  offset_o,
  output logic [TIME_BITS-1:0]  rtt_o
);

  localparam int unsigned IdxW = $clog2(WINDOW_DEPTH);
  localparam int unsigned CntW = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned OW   = TIME_BITS + 1;
  localparam int unsigned HiW  = OW + 1 - 16;

  logic signed [OW-1:0] win_q [WINDOW_DEPTH];
  logic signed [OW-1:0] srt_q [WINDOW_DEPTH];
  logic signed [OW-1:0] srt_d [WINDOW_DEPTH];
  logic [CntW-1:0]      fill_q;
  logic [IdxW-1:0]      oldest_q;
  logic                 seed_q;
  logic signed [OW-1:0] avg_off_q;
  logic [TIME_BITS-1:0] avg_rtt_q;
  logic signed [OW-1:0] raw_q;
  logic [TIME_BITS-1:0] rtt_q;
  logic                 phase_q;
  logic                 ok_q;
  logic                 accepted_q;
  logic [16:0]          a_q;
  logic [16:0]          b_q;

  // Partial product registers: value*w = hi*w*65536 + lo*w.
  logic signed [OW+18:0] po_hi_q, ps_hi_q;
  logic signed [33:0]    po_lo_q, ps_lo_q;
  logic signed [OW+18:0] pr_hi_q, prs_hi_q;
  logic signed [33:0]    pr_lo_q, prs_lo_q;

  // Compute rtt and raw offset from the captured stamps.
  logic [TIME_BITS:0]   rtt_diff;
  logic [TIME_BITS-1:0] rtt_c;
  logic signed [OW+1:0] raw_c;
  assign rtt_diff = {1'b0, recv_i} - {1'b0, send_i};
  assign rtt_c    = rtt_diff[TIME_BITS] ? '0 : rtt_diff[TIME_BITS-1:0];
  assign raw_c    = $signed({3'b0, server_i}) - $signed({3'b0, send_i})
                  - $signed({4'b0, rtt_c[TIME_BITS-1:1]});

  assign sts_o.gate_on = (fill_q != '0) && (32'(fill_q) >= 32'(gate_i));

  // One odd-even transposition step over the sort buffer.
  always_comb begin
    for (int i = 0; i < WINDOW_DEPTH; i++) srt_d[i] = srt_q[i];
    for (int i = 0; i + 1 < WINDOW_DEPTH; i++) begin
      if ((i % 2) == (phase_q ? 1 : 0) && (i + 1) < int'(fill_q)) begin
        if (srt_q[i] > srt_q[i+1]) begin
          srt_d[i]   = srt_q[i+1];
          srt_d[i+1] = srt_q[i];
        end
      end
    end
  end

  // Median of the sorted buffer and distance to the raw offset.
  logic [CntW-1:0]      half;
  logic signed [OW:0]   med_sum;
  logic signed [OW:0]   med;
  logic signed [OW+1:0] dev_s;
  logic [OW+1:0]        dev;
  assign half    = fill_q >> 1;
  always_comb begin
    if (fill_q[0]) med_sum = {srt_q[half[IdxW-1:0]], 1'b0};
    else med_sum = OW'(0) + srt_q[half[IdxW-1:0] - 1'b1] + srt_q[half[IdxW-1:0]];
    med = (med_sum + ((med_sum < 0) ? 1 : 0)) >>> 1;
  end
  assign dev_s = raw_q - med;
  assign dev   = dev_s[OW+1] ? (OW+2)'(-dev_s) : (OW+2)'(dev_s);

  // Blend: quotients of the exact offset and rtt numerators, truncated toward zero.
  logic signed [OW+20:0] num;
  logic signed [OW+20:0] num_r;
  logic signed [OW+20:0] qo, qr;
  always_comb begin
    num = ((OW+21)'(po_hi_q) <<< 16) + ((OW+21)'(ps_hi_q) <<< 16) + po_lo_q + ps_lo_q;
    qo  = (num + ((num < 0) ? (OW+21)'(65535) : '0)) >>> 16;
    num_r = ((OW+21)'(pr_hi_q) <<< 16) + ((OW+21)'(prs_hi_q) <<< 16) + pr_lo_q + prs_lo_q;
    qr  = num_r >>> 16;
  end

  logic [IdxW:0] slot_sum;
  assign slot_sum = {1'b0, oldest_q} + fill_q[IdxW:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      raw_q   <= OW'(raw_c);
      rtt_q   <= rtt_c;
      ok_q    <= 1'b1;
      a_q     <= (alpha_i > 17'(QOne)) ? 17'(QOne) : alpha_i;
    end
    if (cmd_i.sort_init) begin
      // Below full the oldest slot stays at zero, so slot order covers the valid entries.
      for (int i = 0; i < WINDOW_DEPTH; i++) srt_q[i] <= win_q[i];
      phase_q <= 1'b0;
    end
    if (cmd_i.sort_step) begin
      srt_q   <= srt_d;
      phase_q <= !phase_q;
    end
    if (cmd_i.decide) begin
      b_q <= 17'(QOne) - a_q;
      if (sts_o.gate_on && dev > (OW+2)'(reject_i)) ok_q <= 1'b0;
    end
    if (cmd_i.mul_lo) begin
      po_lo_q  <= $signed({1'b0, raw_q[15:0]}) * $signed({1'b0, a_q});
      ps_lo_q  <= $signed({1'b0, avg_off_q[15:0]}) * $signed({1'b0, b_q});
      pr_lo_q  <= $signed({1'b0, rtt_q[15:0]}) * $signed({1'b0, a_q});
      prs_lo_q <= $signed({1'b0, avg_rtt_q[15:0]}) * $signed({1'b0, b_q});
    end
    if (cmd_i.mul_hi) begin
      po_hi_q  <= $signed(raw_q[OW-1:16]) * $signed({1'b0, a_q});
      ps_hi_q  <= $signed(avg_off_q[OW-1:16]) * $signed({1'b0, b_q});
      pr_hi_q  <= $signed({2'b0, rtt_q[TIME_BITS-1:16]}) * $signed({1'b0, a_q});
      prs_hi_q <= $signed({2'b0, avg_rtt_q[TIME_BITS-1:16]}) * $signed({1'b0, b_q});
    end
    if (cmd_i.commit && ok_q) begin
      if (fill_q < CntW'(WINDOW_DEPTH))
        win_q[(slot_sum >= (IdxW+1)'(WINDOW_DEPTH)) ?
              IdxW'(slot_sum - (IdxW+1)'(WINDOW_DEPTH)) : IdxW'(slot_sum)] <= raw_q;
      else win_q[oldest_q] <= raw_q;
    end
  end

  // Update fill, oldest slot, accepted flag, seed and averages on commit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q     <= '0;
      oldest_q   <= '0;
      seed_q     <= 1'b0;
      avg_off_q  <= '0;
      avg_rtt_q  <= '0;
      accepted_q <= 1'b0;
    end else if (cmd_i.commit) begin
      accepted_q <= ok_q;
      if (ok_q) begin
        if (fill_q < CntW'(WINDOW_DEPTH)) fill_q <= fill_q + 1'b1;
        else oldest_q <= (32'(oldest_q) == WINDOW_DEPTH - 1) ? '0 : oldest_q + 1'b1;
        seed_q <= 1'b1;
        if (!seed_q) begin
          avg_off_q <= raw_q;
          avg_rtt_q <= rtt_q;
        end else begin
          avg_off_q <= OW'(qo);
          avg_rtt_q <= TIME_BITS'(qr);
        end
      end
    end
  end

  assign accepted_o  = accepted_q;
  assign est_valid_o = seed_q;
  assign offset_o    = avg_off_q;
  assign rtt_o       = avg_rtt_q;

`include "clock_offset_estimator_core_assert.svh"
  `COE_ASSERT_IMP(a_fill_range, clk_i, rst_ni, 1'b1, fill_q <= CntW'(WINDOW_DEPTH))
  `COE_ASSERT_NEXT(a_seed_sticky, clk_i, rst_ni, seed_q, seed_q)
  `COE_ASSERT_IMP(a_fill_seed, clk_i, rst_ni, fill_q != '0, seed_q)

endmodule

/* hw/rtl/clock_offset_estimator_core.sv */
// Steps from input transfer to result valid: load; with the gate on, copy the window and
//   run WINDOW_DEPTH sort passes; then decide, low and high partial products, and commit.
// The block takes no new item until the previous one has committed;
//   a result not yet taken holds the next item at its commit step.
// The sort is an odd-even transposition over WINDOW_DEPTH passes on a copy of the window.
// Reset: rst_ni asynchronous, clears fill, seed and averages; window entries unset.
// ----------------------------------------------------------------------------
// clock_offset_estimator_core
// Round-trip clock offset estimator with median gate and EWMA smoothing.
// ----------------------------------------------------------------------------
module clock_offset_estimator_core
  import coe_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = 16,
  parameter int unsigned TIME_BITS    = 48
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [TIME_BITS-1:0] client_send_time_i,
  input  logic [TIME_BITS-1:0] server_reply_time_i,
  input  logic [TIME_BITS-1:0] client_receive_time_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 accepted_o,
  output logic                 estimate_valid_o,
  output logic signed [TIME_BITS:0] offset_estimate_ms_o,
  output logic [TIME_BITS-1:0] rtt_estimate_ms_o
);

  logic [31:0] reject_q;
  logic [4:0]  gate_q;
  logic [16:0] alpha_q;
  coe_cmd_t    cmd;
  coe_sts_t    sts;

  assign pready = 1'b1;

  // Write configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reject_q <= 32'd500;
      gate_q   <= 5'd4;
      alpha_q  <= 17'd6554;
    end else if (psel && penable && pwrite) begin
      unique case (paddr)
        RegReject: reject_q <= pwdata;
        RegGate:   gate_q   <= pwdata[4:0];
        RegAlpha:  alpha_q  <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  // Read back configuration registers.
  always_comb begin
    unique case (paddr)
      RegReject: prdata = reject_q;
      RegGate:   prdata = {27'b0, gate_q};
      RegAlpha:  prdata = {15'b0, alpha_q};
      default:   prdata = '0;
    endcase
  end

  coe_ctrl #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  coe_datapath #(.WINDOW_DEPTH(WINDOW_DEPTH), .TIME_BITS(TIME_BITS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .send_i(client_send_time_i), .server_i(server_reply_time_i),
    .recv_i(client_receive_time_i),
    .reject_i(reject_q), .gate_i(gate_q), .alpha_i(alpha_q),
    .accepted_o, .est_valid_o(estimate_valid_o),
    .offset_o(offset_estimate_ms_o), .rtt_o(rtt_estimate_ms_o)
  );

endmodule

/* tb/clock_offset_estimator_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clock_offset_estimator_checker
// Watches the register port and both transfer channels of the estimator,
// keeps its own copy of the window and averages, and compares every result.
// ----------------------------------------------------------------------------
module clock_offset_estimator_checker
  import coe_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [3:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  input  logic        pready_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [47:0] send_i,
  input  logic [47:0] reply_i,
  input  logic [47:0] receive_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic        accepted_i,
  input  logic        estimate_valid_i,
  input  logic signed [48:0] offset_i,
  input  logic [47:0] rtt_i,
  output int          mismatches_o,
  output int          pending_o,
  output int          rejects_o
);

  localparam int Depth = 16;
  localparam int ExpectDepth = 64;

  typedef struct packed {
    logic              accepted;
    logic              estimate_valid;
    logic signed [48:0] offset;
    logic [47:0]       rtt;
  } estimate_t;

  // Ring of expected results, indexed by running write and read counts
  estimate_t   expected_mem[ExpectDepth];
  int          wr_count;
  int          rd_count;

  // Shadow configuration and estimator state
  logic [31:0] reject_limit;
  logic [4:0]  gate_fill;
  logic [16:0] alpha;
  longint      window[Depth];
  int          fill;
  int          oldest;
  bit          seeded;
  longint      avg_offset;
  longint      avg_rtt;

  // Exact (w*x + (1-w)*s) in Q1.16, quotient truncated toward zero
  function automatic longint blend_q16(longint x, longint s, int unsigned a);
    logic signed [127:0] xw, sw, wa, wb, num;
    xw = x;
    sw = s;
    wa = a;
    wb = QOne - a;
    num = xw * wa + sw * wb;
    num = num / 65536;
    return longint'(num);
  endfunction

  function automatic longint window_median();
    longint tmp[Depth];
    longint v;
    int     j;
    for (int i = 0; i < fill; i++) tmp[i] = window[(oldest + i) % Depth];
    for (int i = 1; i < fill; i++) begin
      v = tmp[i];
      j = i;
      while (j > 0 && tmp[j-1] > v) begin
        tmp[j] = tmp[j-1];
        j--;
      end
      tmp[j] = v;
    end
    if (fill % 2) return tmp[fill/2];
    return (tmp[fill/2-1] + tmp[fill/2]) / 2;
  endfunction

  // Advance the shadow state by one round trip and return its result
  function automatic estimate_t estimate_round_trip(logic [47:0] t0, logic [47:0] ts,
                                                    logic [47:0] t1);
    estimate_t   res;
    longint      rtt, raw, med, dev;
    bit          ok;
    int unsigned a;
    rtt = longint'(t1) - longint'(t0);
    if (rtt < 0) rtt = 0;
    raw = longint'(ts) - (longint'(t0) + rtt / 2);
    ok = 1;
    if (fill > 0 && fill >= gate_fill) begin
      med = window_median();
      dev = (raw >= med) ? raw - med : med - raw;
      if (dev > longint'(reject_limit)) ok = 0;
    end
    if (ok) begin
      if (fill < Depth) begin
        window[(oldest + fill) % Depth] = raw;
        fill++;
      end else begin
        window[oldest] = raw;
        oldest = (oldest + 1) % Depth;
      end
      if (!seeded) begin
        avg_offset = raw;
        avg_rtt = rtt;
        seeded = 1;
      end else begin
        a = (alpha > QOne) ? QOne : alpha;
        avg_offset = blend_q16(raw, avg_offset, a);
        avg_rtt = blend_q16(rtt, avg_rtt, a);
      end
    end
    res.accepted = ok;
    res.estimate_valid = seeded;
    res.offset = avg_offset[48:0];
    res.rtt = avg_rtt[47:0];
    return res;
  endfunction

  assign pending_o = wr_count - rd_count;

  always @(posedge clk_i or negedge rst_ni) begin
    estimate_t want;
    estimate_t got;
    if (!rst_ni) begin
      reject_limit <= 32'd500;
      gate_fill <= 5'd4;
      alpha <= 17'd6554;
      fill = 0;
      oldest = 0;
      seeded = 0;
      avg_offset = 0;
      avg_rtt = 0;
      mismatches_o <= 0;
      rejects_o <= 0;
      wr_count = 0;
      rd_count = 0;
    end else begin
      // Track register writes
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i)
          RegReject: reject_limit <= pwdata_i;
          RegGate:   gate_fill <= pwdata_i[4:0];
          RegAlpha:  alpha <= pwdata_i[16:0];
          default: ;
        endcase
      end
      // Compare result transfers against the oldest expectation
      if (out_valid_i && out_ready_i) begin
        got = '{accepted_i, estimate_valid_i, offset_i, rtt_i};
        if (wr_count == rd_count) begin
          mismatches_o <= mismatches_o + 1;
          if (mismatches_o < 10) $display("%0t: result with nothing expected: %p", $time, got);
        end else begin
          want = expected_mem[rd_count % ExpectDepth];
          rd_count++;
          if (!want.accepted) rejects_o <= rejects_o + 1;
          if (got !== want) begin
            mismatches_o <= mismatches_o + 1;
            if (mismatches_o < 10)
              $display({"%0t: expected acc=%0d val=%0d off=%0d rtt=%0d,",
                        " got acc=%0d val=%0d off=%0d rtt=%0d"},
                       $time, want.accepted, want.estimate_valid, want.offset, want.rtt,
                       got.accepted, got.estimate_valid, got.offset, got.rtt);
          end
        end
      end
      // Predict input transfers
      if (in_valid_i && in_ready_i) begin
        expected_mem[wr_count % ExpectDepth] = estimate_round_trip(send_i, reply_i, receive_i);
        wr_count++;
      end
    end
  end

endmodule

/* tb/clock_offset_estimator_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clock_offset_estimator_core_tb
// Drives directed and random round trips through the estimator across several
// gate, reject and smoothing settings, with bursty input and a stalling sink.
// ----------------------------------------------------------------------------
module clock_offset_estimator_core_tb;
  import coe_pkg::*;

  localparam int IdleLimit = 5000;
  localparam int DrainCycles = 40;
  localparam logic [47:0] TMax = 48'hFFFF_FFFF_FFFF;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [47:0] send_t = '0, reply_t = '0, receive_t = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        accepted, estimate_valid;
  logic signed [48:0] offset_est;
  logic [47:0] rtt_est;
  int          mismatches, pending, rejects;
  int          items_sent = 0;
  int          idle_cycles = 0;
  int          gap_left = 0;
  bit          hold_req = 0;
  longint      base_offset;

  always #4 clk_i = ~clk_i;

  clock_offset_estimator_core dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .client_send_time_i(send_t), .server_reply_time_i(reply_t),
    .client_receive_time_i(receive_t),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .accepted_o(accepted), .estimate_valid_o(estimate_valid),
    .offset_estimate_ms_o(offset_est), .rtt_estimate_ms_o(rtt_est)
  );

  clock_offset_estimator_checker checker_i (
    .clk_i, .rst_ni, .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite),
    .paddr_i(paddr), .pwdata_i(pwdata), .pready_i(pready),
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .send_i(send_t), .reply_i(reply_t), .receive_i(receive_t),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .accepted_i(accepted), .estimate_valid_i(estimate_valid),
    .offset_i(offset_est), .rtt_i(rtt_est),
    .mismatches_o(mismatches), .pending_o(pending), .rejects_o(rejects)
  );

  // Stall the sink: long hold-off on request, else alternate free and random stretches
  always begin
    int stretch;
    bit free_run;
    @(posedge clk_i);
    if (hold_req) begin
      out_ready <= 1'b0;
      repeat (400) @(posedge clk_i);
      hold_req = 0;
    end else begin
      free_run = ($urandom_range(0, 2) == 0);
      stretch = $urandom_range(1, 60);
      out_ready <= free_run ? 1'b1 : 1'($urandom_range(0, 9) < 6);
      repeat (stretch - 1) begin
        @(posedge clk_i);
        if (!free_run) out_ready <= 1'($urandom_range(0, 9) < 6);
      end
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("watchdog expired with %0d results outstanding", pending);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic reg_write(logic [3:0] addr, logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Let the checker see the last transfer, then wait for every result
  task automatic drain();
    @(posedge clk_i);
    wait (pending == 0);
  endtask

  // Wait for the pipeline to empty, then program all three registers
  task automatic configure(logic [31:0] limit, logic [4:0] gate, logic [16:0] a);
    drain();
    repeat (DrainCycles) @(posedge clk_i);
    reg_write(RegReject, limit);
    reg_write(RegGate, {27'd0, gate});
    reg_write(RegAlpha, {15'd0, a});
  endtask

  // Offer one round trip, hold until transferred, then maybe open a gap
  task automatic send_trip(logic [47:0] t0, logic [47:0] ts, logic [47:0] t1);
    in_valid <= 1'b1;
    send_t <= t0;
    reply_t <= ts;
    receive_t <= t1;
    do @(posedge clk_i); while (!in_ready);
    items_sent++;
    if (gap_left == 0) begin
      gap_left = $urandom_range(1, 12);
      if ($urandom_range(0, 1)) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end else begin
      gap_left--;
    end
  endtask

  function automatic logic [47:0] rand48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  // Mostly consistent round trips around the current offset, some outliers and noise
  task automatic send_random();
    longint t0, rtt, jitter;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      send_trip(rand48(), rand48(), rand48());
    end else begin
      t0 = longint'(rand48());
      rtt = $urandom_range(0, 600);
      jitter = longint'($urandom_range(0, 400)) - 200;
      if (pick < 24) jitter = jitter * longint'($urandom_range(5, 5000));
      if ($urandom_range(0, 49) == 0) base_offset += longint'($urandom_range(0, 4000)) - 2000;
      send_trip(48'(t0), 48'(t0 + rtt / 2 + base_offset + jitter), 48'(t0 + rtt));
    end
  endtask

  initial begin
    logic [31:0] limits[6];
    logic [4:0]  gates[6];
    logic [16:0] alphas[6];
    limits = '{32'd100, 32'd0, 32'hFFFF_FFFF, 32'd2000, 32'd50, 32'd1000};
    gates  = '{5'd1, 5'd0, 5'd16, 5'd31, 5'd8, 5'd4};
    alphas = '{17'd65536, 17'd0, 17'h1FFFF, 17'd30000, 17'd1, 17'd6554};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, receive before send, consistent fill, then outliers
    send_trip('0, '0, '0);
    send_trip(TMax, TMax, TMax);
    send_trip(TMax, 48'd5, '0);
    send_trip('0, TMax, TMax);
    send_trip(TMax, '0, TMax);
    for (int i = 0; i < 6; i++)
      send_trip(48'd1000 + 48'(i), 48'd1500 + 48'(i), 48'd1010 + 48'(i));
    send_trip(48'd2000, 48'd900000, 48'd2010);
    send_trip(48'd2000, 48'd2400, 48'd2100);
    send_trip(48'd3000, 48'd1, 48'd3002);

    base_offset = 0;
    for (int i = 0; i < 150; i++) send_random();

    // Fill the block while the sink holds off, then pause until drained
    hold_req = 1;
    for (int i = 0; i < 40; i++) send_random();
    in_valid <= 1'b0;
    drain();

    for (int p = 0; p < 6; p++) begin
      in_valid <= 1'b0;
      configure(limits[p], gates[p], alphas[p]);
      base_offset = longint'($urandom_range(0, 2000000)) - 1000000;
      for (int i = 0; i < 185; i++) send_random();
    end
    in_valid <= 1'b0;

    drain();
    repeat (DrainCycles) @(posedge clk_i);
    $display("%0d round trips over 7 register settings, %0d rejected by the outlier gate",
             items_sent, rejects);
    $display("long sink hold-off and full drain pause both exercised");
    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* clock_offset_estimator_core.f */
+incdir+hw/rtl
hw/rtl/coe_pkg.sv
hw/rtl/coe_ctrl.sv
hw/rtl/coe_datapath.sv
hw/rtl/clock_offset_estimator_core.sv
tb/clock_offset_estimator_checker.sv
tb/clock_offset_estimator_core_tb.sv
